// ===== src/gqc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register codes and constants of the quadratic classifier.
// Used by every module of the block; depends on nothing.
package gqc_pkg;

	// Word of the point channel.
	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               true_class;
	} point_word_t;

	// Word of the result channel.
	typedef struct packed {
		logic               chosen_class;
		logic signed [31:0] score_a;
		logic signed [31:0] score_b;
		logic               misclassified;
	} result_word_t;

	// Configuration register file.
	typedef struct packed {
		logic [31:0] mean_a;
		logic [31:0] mean_b;
		logic [47:0] cov_a;
		logic [47:0] cov_b;
		logic [15:0] prior_a;
		logic [15:0] prior_b;
	} cfg_regs_t;

	// Point-independent terms of one class, all Q16.16.
	typedef struct packed {
		logic signed [31:0] ixx;
		logic signed [31:0] ixy;
		logic signed [31:0] iyy;
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] bias;
	} class_coef_t;

	typedef class_coef_t [1:0] coef_t;

	// Register indexes on the configuration port.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COV_A   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COV_B   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRIOR_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRIOR_B = 3'd5;
	localparam int CFG_DATA_W = 48;

	// Register values after reset.
	localparam logic [31:0] RST_MEAN_A  = 32'd16777472;
	localparam logic [31:0] RST_MEAN_B  = 32'd67109888;
	localparam logic [47:0] RST_COV_A   = 48'd1099511628032;
	localparam logic [47:0] RST_COV_B   = 48'd4398046513152;
	localparam logic [15:0] RST_PRIOR_A = 16'd32768;
	localparam logic [15:0] RST_PRIOR_B = 16'd32768;

	// Divider and log unit sizes.
	localparam int DIV_W     = 41;
	localparam int DET_W     = 31;
	localparam int FRAC_BITS = 20;
	localparam int EXP_W     = 5;
	localparam int LOG_W     = EXP_W + FRAC_BITS;

	localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
	localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

	// Clamp a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/gaussian_quadratic_classifier.sv =====
`timescale 1ns / 1ps
// Two-class Gaussian quadratic discriminant classifier on 2-D Q8.8 points.
// Point channel: point_valid/point_stall carry one point word (x, y, label).
// Result channel: result_valid/result_stall carry the chosen class, both
// Q16.16 scores and a misclassified flag, one word per point, in order.
// A word moves at a clock edge where valid is high and stall is low.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (means, covariances, priors); cfg_ready is always high, unknown indexes
// are dropped. Write only while no point is in flight.
// One point per cycle is taken while the result side keeps up and no
// derivation is running. A stalled result word holds, and the pipeline
// keeps filling empty stages behind it before it raises point_stall.
// After reset, and after every write to a known register index, a sequencer
// derives the inverse covariance, linear and bias terms of both classes
// with the bit-serial divider and the log unit. point_stall stays high
// meanwhile.
// Depends on gqc_pkg, gqc_derive and gqc_score.
module gaussian_quadratic_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               point_valid,
	output logic                               point_stall,
	input  gqc_pkg::point_word_t               point,
	output logic                               result_valid,
	input  logic                               result_stall,
	output gqc_pkg::result_word_t              result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gqc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gqc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gqc_pkg::*;

	cfg_regs_t cfg_q;
	logic      restart;
	logic      busy;
	coef_t     coef;

	assign cfg_ready = 1'b1;

	// Register file; a known index starts a new derivation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_a  <= RST_MEAN_A;
			cfg_q.mean_b  <= RST_MEAN_B;
			cfg_q.cov_a   <= RST_COV_A;
			cfg_q.cov_b   <= RST_COV_B;
			cfg_q.prior_a <= RST_PRIOR_A;
			cfg_q.prior_b <= RST_PRIOR_B;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MEAN_A:  cfg_q.mean_a  <= cfg_data[31:0];
				REG_MEAN_B:  cfg_q.mean_b  <= cfg_data[31:0];
				REG_COV_A:   cfg_q.cov_a   <= cfg_data;
				REG_COV_B:   cfg_q.cov_b   <= cfg_data;
				REG_PRIOR_A: cfg_q.prior_a <= cfg_data[15:0];
				REG_PRIOR_B: cfg_q.prior_b <= cfg_data[15:0];
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_index)
			REG_MEAN_A, REG_MEAN_B, REG_COV_A, REG_COV_B, REG_PRIOR_A, REG_PRIOR_B:
				restart = cfg_valid && cfg_ready;
			default: restart = 1'b0;
		endcase
	end

	gqc_derive u_derive (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.cfg     (cfg_q),
		.busy    (busy),
		.coef    (coef)
	);

	gqc_score u_score (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold         (busy),
		.coef         (coef),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== src/gqc_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on gqc_pkg for the operand widths.
module gqc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gqc_pkg::DIV_W-1:0]  dividend,
	input  logic [gqc_pkg::DET_W-1:0]  divisor,
	output logic                       done,
	output logic [gqc_pkg::DIV_W-1:0]  quotient
);
	import gqc_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [DET_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DET_W:0]   trial;
	logic [DET_W:0]   diff;
	logic             fits;

	// Next partial remainder and whether the divisor goes into it.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DET_W-1:0] : trial[DET_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/gqc_log2.sv =====
`timescale 1ns / 1ps
// Base-2 logarithm with 20 fraction bits: normalize one bit a cycle, then
// one squaring a cycle. Depends on gqc_pkg for widths.
module gqc_log2 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gqc_pkg::DET_W-1:0]  x,
	output logic                       done,
	output logic [gqc_pkg::LOG_W-1:0]  result
);
	import gqc_pkg::*;

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_NORM = 2'd1;
	localparam logic [1:0] L_SQR  = 2'd2;

	logic [1:0]           st_q;
	logic [4:0]           cnt_q;
	logic                 done_q;
	logic [DET_W-1:0]     m_q;
	logic [EXP_W-1:0]     n_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [2*DET_W-1:0]   sq;
	logic [DET_W:0]       m2;

	// Square of the Q1.30 mantissa, back to Q1.30 with one extra top bit.
	assign sq = m_q * m_q;
	assign m2 = sq[2*DET_W-1:DET_W-1];

	// Phase control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				st_q <= L_NORM;
			end else begin
				case (st_q)
					L_NORM: begin
						if (m_q[DET_W-1]) begin
							st_q  <= L_SQR;
							cnt_q <= 5'(FRAC_BITS);
						end
					end
					L_SQR: begin
						cnt_q <= cnt_q - 5'd1;
						if (cnt_q == 5'd1) begin
							st_q   <= L_IDLE;
							done_q <= 1'b1;
						end
					end
					default: st_q <= L_IDLE;
				endcase
			end
		end
	end

	// Mantissa, exponent and fraction bits.
	always_ff @(posedge clk) begin
		if (start) begin
			m_q    <= x;
			n_q    <= 5'(DET_W - 1);
			frac_q <= '0;
		end else if (st_q == L_NORM && !m_q[DET_W-1]) begin
			m_q <= {m_q[DET_W-2:0], 1'b0};
			n_q <= n_q - 5'd1;
		end else if (st_q == L_SQR) begin
			m_q    <= m2[DET_W] ? m2[DET_W:1] : m2[DET_W-1:0];
			frac_q <= {frac_q[FRAC_BITS-2:0], m2[DET_W]};
		end
	end

	assign done   = done_q;
	assign result = {n_q, frac_q};

endmodule

// ===== src/gqc_derive.sv =====
`timescale 1ns / 1ps
// Sequencer that derives the inverse covariance, linear and bias terms of
// both classes from the register file. Depends on gqc_pkg, gqc_div, gqc_log2.
module gqc_derive (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  gqc_pkg::cfg_regs_t cfg,
	output logic               busy,
	output gqc_pkg::coef_t     coef
);
	import gqc_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DET      = 4'd1;
	localparam logic [3:0] S_DIV_GO   = 4'd2;
	localparam logic [3:0] S_DIV_WAIT = 4'd3;
	localparam logic [3:0] S_WX1      = 4'd4;
	localparam logic [3:0] S_WX2      = 4'd5;
	localparam logic [3:0] S_WY1      = 4'd6;
	localparam logic [3:0] S_WY2      = 4'd7;
	localparam logic [3:0] S_MD1      = 4'd8;
	localparam logic [3:0] S_MD2      = 4'd9;
	localparam logic [3:0] S_LD_GO    = 4'd10;
	localparam logic [3:0] S_LD_WAIT  = 4'd11;
	localparam logic [3:0] S_LP_GO    = 4'd12;
	localparam logic [3:0] S_LP_WAIT  = 4'd13;
	localparam logic [3:0] S_T1       = 4'd14;
	localparam logic [3:0] S_T2       = 4'd15;

	localparam logic signed [33:0] LN2_Q32  = 34'sd2977044472;
	localparam logic signed [25:0] LOG_BIAS = 26'sd16777216;
	localparam logic signed [67:0] RND_8    = 68'sd128;
	localparam logic signed [67:0] RND_9    = 68'sd256;
	localparam logic signed [67:0] RND_36   = 68'sd68719476736;
	localparam logic signed [67:0] RND_35   = 68'sd34359738368;

	logic [3:0]              st_q;
	logic                    k_q;
	logic [1:0]              j_q;
	logic                    neg_q;
	logic [DET_W-1:0]        det_q;
	logic signed [47:0]      acc_q;
	logic signed [40:0]      t0_q;
	logic signed [23:0]      t1_q;
	logic signed [25:0]      ld_q;
	logic signed [25:0]      lp_q;
	coef_t                   coef_q;

	logic [47:0]             cov;
	logic [31:0]             mean;
	logic [15:0]             prior_raw;
	logic [DET_W-1:0]        prior_x;
	logic signed [15:0]      sxx, sxy, syy, mx, my;
	class_coef_t             cur;
	logic signed [31:0]      pxx, pxy;
	logic signed [32:0]      det_full;
	logic [DET_W-1:0]        det_pos;
	logic signed [16:0]      num;
	logic [16:0]             mag;
	logic [DIV_W-1:0]        dividend;
	logic                    div_start, div_done;
	logic [DIV_W-1:0]        quotient;
	logic signed [67:0]      qs;
	logic signed [31:0]      inv_val;
	logic signed [31:0]      ma;
	logic signed [15:0]      mb;
	logic signed [47:0]      prod48;
	logic signed [67:0]      wsum;
	logic signed [31:0]      w_val;
	logic signed [67:0]      mdw;
	logic signed [67:0]      t0_full;
	logic                    log_start, log_done;
	logic [DET_W-1:0]        log_x;
	logic [LOG_W-1:0]        log_res;
	logic signed [25:0]      log_val;
	logic signed [25:0]      lsel;
	logic signed [59:0]      prod_ln;
	logic signed [67:0]      t1_full;
	logic signed [67:0]      t2_full;
	logic signed [31:0]      bias_val;

	// Operands of the class being worked on.
	always_comb begin
		cov       = k_q ? cfg.cov_b : cfg.cov_a;
		mean      = k_q ? cfg.mean_b : cfg.mean_a;
		prior_raw = k_q ? cfg.prior_b : cfg.prior_a;
		sxx       = signed'(cov[47:32]);
		sxy       = signed'(cov[31:16]);
		syy       = signed'(cov[15:0]);
		mx        = signed'(mean[31:16]);
		my        = signed'(mean[15:0]);
		prior_x   = (prior_raw == 16'd0) ? DET_W'(1) : DET_W'(prior_raw);
		cur       = coef_q[k_q];
	end

	// Determinant; a value that is not positive counts as one LSB.
	always_comb begin
		pxx      = sxx * syy;
		pxy      = sxy * sxy;
		det_full = 33'(pxx) - 33'(pxy);
		det_pos  = (det_full > 33'sd0) ? det_full[DET_W-1:0] : DET_W'(1);
	end

	// Dividend of the current inverse entry, with half the divisor added.
	always_comb begin
		if (j_q == 2'd0) begin
			num = 17'(syy);
		end else if (j_q == 2'd1) begin
			num = -17'(sxy);
		end else begin
			num = 17'(sxx);
		end
		mag      = num[16] ? 17'(-num) : 17'(num);
		dividend = {mag, 24'd0} + DIV_W'(det_q >> 1);
		qs       = signed'(68'(quotient));
		inv_val  = sat32(neg_q ? -qs : qs);
	end

	// Shared 32x16 multiplier for the linear terms and m'w.
	always_comb begin
		case (st_q)
			S_WX1:   begin ma = cur.ixx; mb = mx; end
			S_WX2:   begin ma = cur.ixy; mb = my; end
			S_WY1:   begin ma = cur.ixy; mb = mx; end
			S_WY2:   begin ma = cur.iyy; mb = my; end
			S_MD1:   begin ma = cur.wx;  mb = mx; end
			default: begin ma = cur.wy;  mb = my; end
		endcase
		prod48  = ma * mb;
		wsum    = 68'(acc_q) + 68'(prod48) + RND_8;
		w_val   = sat32(wsum >>> 8);
		mdw     = 68'(acc_q) + 68'(prod48);
		t0_full = (RND_9 - mdw) >>> 9;
	end

	// Log terms scaled by ln 2.
	always_comb begin
		log_x    = (st_q == S_LP_GO) ? prior_x : det_q;
		log_val  = signed'({1'b0, log_res}) - LOG_BIAS;
		lsel     = (st_q == S_T1) ? ld_q : lp_q;
		prod_ln  = lsel * LN2_Q32;
		t1_full  = (RND_36 - 68'(prod_ln)) >>> 37;
		t2_full  = (68'(prod_ln) + RND_35) >>> 36;
		bias_val = sat32(68'(t0_q) + 68'(t1_q) + t2_full);
	end

	assign div_start = (st_q == S_DIV_GO);
	assign log_start = (st_q == S_LD_GO) || (st_q == S_LP_GO);

	gqc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (det_q),
		.done     (div_done),
		.quotient (quotient)
	);

	gqc_log2 u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	// Sequencer; a register write starts the whole derivation over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_DET;
			k_q  <= 1'b0;
			j_q  <= 2'd0;
		end else if (restart) begin
			st_q <= S_DET;
			k_q  <= 1'b0;
			j_q  <= 2'd0;
		end else begin
			case (st_q)
				S_IDLE:   st_q <= S_IDLE;
				S_DET: begin
					st_q <= S_DIV_GO;
					j_q  <= 2'd0;
				end
				S_DIV_GO: st_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						if (j_q == 2'd2) begin
							st_q <= S_WX1;
						end else begin
							j_q  <= j_q + 2'd1;
							st_q <= S_DIV_GO;
						end
					end
				end
				S_WX1:    st_q <= S_WX2;
				S_WX2:    st_q <= S_WY1;
				S_WY1:    st_q <= S_WY2;
				S_WY2:    st_q <= S_MD1;
				S_MD1:    st_q <= S_MD2;
				S_MD2:    st_q <= S_LD_GO;
				S_LD_GO:  st_q <= S_LD_WAIT;
				S_LD_WAIT: begin
					if (log_done) begin
						st_q <= S_LP_GO;
					end
				end
				S_LP_GO:  st_q <= S_LP_WAIT;
				S_LP_WAIT: begin
					if (log_done) begin
						st_q <= S_T1;
					end
				end
				S_T1:     st_q <= S_T2;
				S_T2: begin
					if (k_q) begin
						st_q <= S_IDLE;
					end else begin
						k_q  <= 1'b1;
						st_q <= S_DET;
					end
				end
				default:  st_q <= S_IDLE;
			endcase
		end
	end

	// Intermediate values and the derived terms.
	always_ff @(posedge clk) begin
		case (st_q)
			S_DET:    det_q <= det_pos;
			S_DIV_GO: neg_q <= num[16];
			S_DIV_WAIT: begin
				if (div_done) begin
					if (j_q == 2'd0) begin
						coef_q[k_q].ixx <= inv_val;
					end else if (j_q == 2'd1) begin
						coef_q[k_q].ixy <= inv_val;
					end else begin
						coef_q[k_q].iyy <= inv_val;
					end
				end
			end
			S_WX1, S_WY1, S_MD1: acc_q <= prod48;
			S_WX2:    coef_q[k_q].wx <= w_val;
			S_WY2:    coef_q[k_q].wy <= w_val;
			S_MD2:    t0_q <= t0_full[40:0];
			S_LD_WAIT: begin
				if (log_done) begin
					ld_q <= log_val;
				end
			end
			S_LP_WAIT: begin
				if (log_done) begin
					lp_q <= log_val;
				end
			end
			S_T1:     t1_q <= t1_full[23:0];
			S_T2:     coef_q[k_q].bias <= bias_val;
			default:  acc_q <= acc_q;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign coef = coef_q;

endmodule

// ===== src/gqc_score.sv =====
`timescale 1ns / 1ps
// Six-stage scoring pipeline: both discriminants, the decision and the
// output register. Depends on gqc_pkg.
module gqc_score (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   hold,
	input  gqc_pkg::coef_t         coef,
	input  logic                   point_valid,
	output logic                   point_stall,
	input  gqc_pkg::point_word_t   point,
	output logic                   result_valid,
	input  logic                   result_stall,
	output gqc_pkg::result_word_t  result
);
	import gqc_pkg::*;

	localparam logic signed [67:0] RND_17 = 68'sd65536;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic truth_s1, truth_s2, truth_s3, truth_s4, truth_s5;

	logic signed [31:0] xx_s1, xy_s1, yy_s1;
	logic signed [47:0] lx_s1 [2];
	logic signed [47:0] ly_s1 [2];
	logic signed [63:0] qa_s2 [2];
	logic signed [63:0] qb_s2 [2];
	logic signed [63:0] qc_s2 [2];
	logic signed [48:0] lin_s2 [2];
	logic signed [65:0] q_s3 [2];
	logic signed [58:0] t_s3 [2];
	logic signed [67:0] v_s4_val [2];
	logic signed [31:0] sc_s5 [2];
	result_word_t       word_s6;

	// Each stage moves when it is empty or the next stage moves.
	assign en6 = !v_s6 || !result_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign point_stall = hold || !en1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= point_valid && !hold;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: squares, cross product and linear products.
	always_ff @(posedge clk) begin
		if (en1) begin
			truth_s1 <= point.true_class;
			xx_s1    <= point.point_x * point.point_x;
			xy_s1    <= point.point_x * point.point_y;
			yy_s1    <= point.point_y * point.point_y;
			for (int k = 0; k < 2; k++) begin
				lx_s1[k] <= coef[k].wx * point.point_x;
				ly_s1[k] <= coef[k].wy * point.point_y;
			end
		end
	end

	// Stage 2: inverse-covariance products and the linear sum.
	always_ff @(posedge clk) begin
		if (en2) begin
			truth_s2 <= truth_s1;
			for (int k = 0; k < 2; k++) begin
				qa_s2[k]  <= coef[k].ixx * xx_s1;
				qb_s2[k]  <= coef[k].ixy * xy_s1;
				qc_s2[k]  <= coef[k].iyy * yy_s1;
				lin_s2[k] <= 49'(lx_s1[k]) + 49'(ly_s1[k]);
			end
		end
	end

	// Stage 3: quadratic form, and linear plus bias in units of 2^-33.
	always_ff @(posedge clk) begin
		if (en3) begin
			truth_s3 <= truth_s2;
			for (int k = 0; k < 2; k++) begin
				q_s3[k] <= 66'(qa_s2[k]) + (66'(qb_s2[k]) <<< 1) + 66'(qc_s2[k]);
				t_s3[k] <= (59'(lin_s2[k]) <<< 9) + (59'(coef[k].bias) <<< 17);
			end
		end
	end

	// Stage 4: full score with the rounding half added.
	always_ff @(posedge clk) begin
		if (en4) begin
			truth_s4 <= truth_s3;
			for (int k = 0; k < 2; k++) begin
				v_s4_val[k] <= 68'(t_s3[k]) + RND_17 - 68'(q_s3[k]);
			end
		end
	end

	// Stage 5: back to Q16.16 and saturate.
	always_ff @(posedge clk) begin
		if (en5) begin
			truth_s5 <= truth_s4;
			for (int k = 0; k < 2; k++) begin
				sc_s5[k] <= sat32(v_s4_val[k] >>> 17);
			end
		end
	end

	// Stage 6: decision into the output register; a tie keeps the label.
	always_ff @(posedge clk) begin
		if (en6) begin
			word_s6.score_a <= sc_s5[0];
			word_s6.score_b <= sc_s5[1];
			if (sc_s5[0] > sc_s5[1]) begin
				word_s6.chosen_class  <= 1'b0;
				word_s6.misclassified <= truth_s5;
			end else if (sc_s5[0] < sc_s5[1]) begin
				word_s6.chosen_class  <= 1'b1;
				word_s6.misclassified <= !truth_s5;
			end else begin
				word_s6.chosen_class  <= truth_s5;
				word_s6.misclassified <= 1'b0;
			end
		end
	end

	assign result_valid = v_s6;
	assign result       = word_s6;

endmodule
